[src/mlmc_pkg.sv]
package mlmc_pkg;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_RES     = 5;
  localparam int unsigned RES_IDX_W   = 3;
  localparam int unsigned DEF_TIMER_W = 16;
  localparam int unsigned DEF_Q_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd3;

  localparam logic [CFG_W-1:0] RST_ON_TIME  = 16'd30000;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd50;
  localparam logic [CFG_W-1:0] RST_HOLD     = 16'd2000;
  localparam logic [CFG_W-1:0] RST_GAP      = 16'd500;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_OFF  = 2'd1;
  localparam logic [1:0] CMD_ON   = 2'd2;

  // one report, lowest bit first: light, presence, mon, moff, auto, ron, roff
  typedef struct packed {
    logic roff_f;
    logic ron_f;
    logic auto_f;
    logic moff_f;
    logic mon_f;
    logic presence;
    logic light;
  } res_t;

  // all reports caused by one tick
  typedef struct packed {
    logic [RES_IDX_W-1:0]   count;
    res_t [MAX_RES-1:0]     res;
  } tick_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } q_stat_t;

endpackage

[src/motion_light_mode_controller_top.sv]
// channel | dir | handshake                    | payload
// --------+-----+------------------------------+-------------------------------------------
// tick in | in  | s_axis_tvalid/s_axis_tready  | tdata: presence, button_level, remote_command
// reports | out | m_axis_tvalid/m_axis_tready  | tdata: 7 flags; tlast: last_of_tick
// config  | in  | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// a tick is taken when s_axis_tvalid and s_axis_tready are both high; a tick with
// reports is queued as one entry, and a tick with none is not queued. the back end
// sends one report beat per cycle while m_axis_tready is high; only queued ticks use the output.
// ticks keep flowing while the queue has room, even with the output stalled.
// reset is asynchronous, active low; it empties the queue and output stage.
module motion_light_mode_controller_top import mlmc_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = DEF_TIMER_W,
  parameter int unsigned QUEUE_DEPTH = DEF_Q_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] presence, [1] button_level, [3:2] remote_command, [7:4] zero
  input  logic [7:0]           s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] light_on, [1] presence_reported, [2] manual_on_flag, [3] manual_off_flag,
  // [4] auto_flag, [5] remote_on_flag, [6] remote_off_flag, [7] zero
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tlast
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  tick_t   q_in, q_head;

  mlmc_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (q_in)
  );

  mlmc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  mlmc_back u_back (
    .clk_i,
    .rst_ni,
    .q_head_i (q_head),
    .q_stat_i (q_stat),
    .q_pop_o  (q_pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

`ifndef SYNTHESIS
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> q_stat.valid)
    else $error("queue empty after push");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.valid)
    else $error("pop from empty queue");

  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.ready |-> q_stat.valid)
    else $error("queue full and empty at once");
`endif

endmodule

[src/mlmc_front.sv]
module mlmc_front import mlmc_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = DEF_TIMER_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  q_stat_t              q_stat_i,
  output logic                 q_push_o,
  output tick_t                q_data_o
);

  localparam int unsigned TW = TIMER_WIDTH;
  localparam int unsigned CW = (TW > CFG_W) ? TW : CFG_W;
  localparam logic [TW-1:0] AGE_MAX = {TW{1'b1}};

  localparam int unsigned A_BTN    = 0;
  localparam int unsigned A_LIGHT  = 1;
  localparam int unsigned A_REMOTE = 2;
  localparam int unsigned A_CHANGE = 3;

  localparam int unsigned F_AUTO = 2;

  typedef enum logic [1:0] {
    MODE_MOTION = 2'd0,
    MODE_ON     = 2'd1,
    MODE_OFF    = 2'd2
  } mode_e;

  logic [CFG_W-1:0] on_time_q, debounce_q, hold_q, gap_q;

  mode_e         mode_q, mode_d;
  logic          forced_q, forced_d;
  logic          rrep_q, rrep_d;
  logic          rdone_q, rdone_d;
  logic          light_q, light_d;
  logic [4:0]    flags_q, flags_d;
  logic          prev_btn_q, prev_btn_d;
  logic [TW-1:0] age_q [4];
  logic [TW-1:0] age_d [4];
  logic          recent_q, recent_d;
  logic          sknown_q, sknown_d;
  logic          sval_q, sval_d;
  logic          held_q, held_d;
  tick_t         tick_d;
  logic          accept;

  logic       pir, btn;
  logic [1:0] cmd;

  assign pir = s_axis_tdata[0];
  assign btn = s_axis_tdata[1];
  assign cmd = s_axis_tdata[3:2];

  function automatic logic older(input logic [TW-1:0] age, input logic [CFG_W-1:0] thr);
    return (age == AGE_MAX) || (CW'(age) > CW'(thr));
  endfunction

  function automatic logic older_eq(input logic [TW-1:0] age, input logic [CFG_W-1:0] thr);
    return (age == AGE_MAX) || (CW'(age) >= CW'(thr));
  endfunction

  // returns {reported, flags}
  function automatic logic [5:0] refresh(input logic forced, input logic rrep,
                                         input mode_e mode, input logic [4:0] flags);
    logic [5:0] r;
    if (forced) begin
      if (!rrep) begin
        r = {1'b1, mode == MODE_OFF, mode == MODE_ON, flags[F_AUTO], 2'b00};
      end else begin
        r = {1'b1, 5'b00100};
      end
    end else begin
      r = {rrep, 2'b00, mode == MODE_MOTION, mode == MODE_OFF, mode == MODE_ON};
    end
    return r;
  endfunction

  function automatic res_t mk_res(input logic lvl, input logic held, input logic [4:0] f);
    res_t r;
    r.light    = lvl;
    r.presence = held;
    r.mon_f    = f[0];
    r.moff_f   = f[1];
    r.auto_f   = f[2];
    r.ron_f    = f[3];
    r.roff_f   = f[4];
    return r;
  endfunction

  always_comb begin
    logic [5:0] rf;
    rf         = '0;
    mode_d     = mode_q;
    forced_d   = forced_q;
    rrep_d     = rrep_q;
    rdone_d    = rdone_q;
    light_d    = light_q;
    flags_d    = flags_q;
    recent_d   = recent_q;
    sknown_d   = sknown_q;
    sval_d     = sval_q;
    held_d     = held_q;
    tick_d     = '0;
    for (int i = 0; i < 4; i++) begin
      age_d[i] = (age_q[i] != AGE_MAX) ? age_q[i] + TW'(1) : age_q[i];
    end

    // remote command
    if (cmd == CMD_OFF || cmd == CMD_ON) begin
      forced_d         = 1'b1;
      mode_d           = (cmd == CMD_OFF) ? MODE_OFF : MODE_ON;
      light_d          = (cmd == CMD_ON);
      rrep_d           = 1'b0;
      age_d[A_REMOTE]  = '0;
      rf               = refresh(forced_d, rrep_d, mode_d, flags_d);
      rrep_d           = rf[5];
      flags_d          = rf[4:0];
      tick_d.res[tick_d.count] = mk_res(light_d, held_d, flags_d);
      tick_d.count     = tick_d.count + RES_IDX_W'(1);
    end

    if (!sknown_d) begin
      sknown_d = 1'b1;
      sval_d   = pir;
    end

    // button edge
    if (btn != prev_btn_q && older(age_d[A_BTN], debounce_q)) begin
      if (btn) begin
        recent_d        = 1'b1;
        age_d[A_CHANGE] = '0;
        if (forced_d) begin
          forced_d = 1'b0;
          mode_d   = MODE_MOTION;
          light_d  = pir;
          if (pir) age_d[A_LIGHT] = '0;
        end else begin
          unique case (mode_d)
            MODE_MOTION: mode_d = MODE_ON;
            MODE_ON:     mode_d = MODE_OFF;
            default:     mode_d = MODE_MOTION;
          endcase
          if (mode_d == MODE_ON) begin
            light_d = 1'b1;
          end else if (mode_d == MODE_MOTION) begin
            light_d = pir;
            if (pir) age_d[A_LIGHT] = '0;
          end else begin
            light_d = 1'b0;
          end
        end
        rf       = refresh(forced_d, rrep_d, mode_d, flags_d);
        rrep_d   = rf[5];
        flags_d  = rf[4:0];
        sknown_d = 1'b1;
        sval_d   = pir;
        tick_d.res[tick_d.count] = mk_res(light_d, held_d, flags_d);
        tick_d.count = tick_d.count + RES_IDX_W'(1);
      end
      age_d[A_BTN] = '0;
    end
    prev_btn_d = btn;

    // motion mode
    if (mode_d == MODE_MOTION && !forced_d) begin
      if (pir && !light_d) begin
        light_d         = 1'b1;
        age_d[A_LIGHT]  = '0;
        recent_d        = 1'b1;
        age_d[A_CHANGE] = '0;
        rf       = refresh(forced_d, rrep_d, mode_d, flags_d);
        rrep_d   = rf[5];
        flags_d  = rf[4:0];
        sknown_d = 1'b1;
        sval_d   = pir;
        tick_d.res[tick_d.count] = mk_res(light_d, held_d, flags_d);
        tick_d.count = tick_d.count + RES_IDX_W'(1);
      end else if (light_d && older_eq(age_d[A_LIGHT], on_time_q)) begin
        light_d         = 1'b0;
        recent_d        = 1'b1;
        age_d[A_CHANGE] = '0;
        rf       = refresh(forced_d, rrep_d, mode_d, flags_d);
        rrep_d   = rf[5];
        flags_d  = rf[4:0];
        sknown_d = 1'b1;
        sval_d   = pir;
        tick_d.res[tick_d.count] = mk_res(light_d, held_d, flags_d);
        tick_d.count = tick_d.count + RES_IDX_W'(1);
      end
    end

    // auto-restore after the hold time
    if (forced_d && older_eq(age_d[A_REMOTE], hold_q)) begin
      if (rrep_d && !rdone_d) begin
        forced_d = 1'b0;
        mode_d   = MODE_MOTION;
        light_d  = pir;
        if (pir) age_d[A_LIGHT] = '0;
        recent_d        = 1'b1;
        age_d[A_CHANGE] = '0;
        rf       = refresh(forced_d, rrep_d, mode_d, flags_d);
        rrep_d   = rf[5];
        flags_d  = rf[4:0];
        sknown_d = 1'b1;
        sval_d   = pir;
        tick_d.res[tick_d.count] = mk_res(light_d, held_d, flags_d);
        tick_d.count = tick_d.count + RES_IDX_W'(1);
        rdone_d  = 1'b1;
      end
    end else if (!forced_d) begin
      rdone_d = 1'b0;
    end

    // presence change, reported unless inside the gap
    held_d = pir;
    if (sval_d != pir) begin
      if (!recent_d || older(age_d[A_CHANGE], gap_q)) begin
        recent_d        = 1'b1;
        age_d[A_CHANGE] = '0;
        rf       = refresh(forced_d, rrep_d, mode_d, flags_d);
        rrep_d   = rf[5];
        flags_d  = rf[4:0];
        sknown_d = 1'b1;
        sval_d   = pir;
        tick_d.res[tick_d.count] = mk_res(light_d, held_d, flags_d);
        tick_d.count = tick_d.count + RES_IDX_W'(1);
      end else begin
        sknown_d = 1'b1;
        sval_d   = pir;
      end
    end

    if (recent_d && older(age_d[A_CHANGE], gap_q)) recent_d = 1'b0;
  end

  assign s_axis_tready = q_stat_i.ready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign q_push_o      = accept && (tick_d.count != '0);
  assign q_data_o      = tick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q  <= RST_ON_TIME;
      debounce_q <= RST_DEBOUNCE;
      hold_q     <= RST_HOLD;
      gap_q      <= RST_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ON_TIME:  on_time_q  <= cfg_data_i;
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        REG_HOLD:     hold_q     <= cfg_data_i;
        REG_GAP:      gap_q      <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_MOTION;
      forced_q   <= 1'b0;
      rrep_q     <= 1'b0;
      rdone_q    <= 1'b0;
      light_q    <= 1'b0;
      flags_q    <= 5'b00100;
      prev_btn_q <= 1'b0;
      for (int i = 0; i < 4; i++) age_q[i] <= AGE_MAX;
      recent_q   <= 1'b0;
      sknown_q   <= 1'b0;
      sval_q     <= 1'b0;
      held_q     <= 1'b0;
    end else if (accept) begin
      mode_q     <= mode_d;
      forced_q   <= forced_d;
      rrep_q     <= rrep_d;
      rdone_q    <= rdone_d;
      light_q    <= light_d;
      flags_q    <= flags_d;
      prev_btn_q <= prev_btn_d;
      for (int i = 0; i < 4; i++) age_q[i] <= age_d[i];
      recent_q   <= recent_d;
      sknown_q   <= sknown_d;
      sval_q     <= sval_d;
      held_q     <= held_d;
    end
  end

endmodule

[src/mlmc_queue.sv]
module mlmc_queue import mlmc_pkg::*; #(
  parameter int unsigned DEPTH = DEF_Q_DEPTH  // power of two, at least 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  tick_t   push_data_i,
  input  logic    pop_i,
  output tick_t   head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  tick_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q, cnt_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.ready = (cnt_q != NW'(DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + NW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[src/mlmc_back.sv]
module mlmc_back import mlmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tick_t      q_head_i,
  input  q_stat_t    q_stat_i,
  output logic       q_pop_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast
);

  tick_t                entry_q;
  logic [RES_IDX_W-1:0] idx_q;
  logic                 busy_q;
  logic                 ovalid_q;
  res_t                 ores_q;
  logic                 olast_q;
  logic                 load;
  logic                 busy_last;

  assign load      = !ovalid_q || m_axis_tready;
  assign busy_last = (idx_q + RES_IDX_W'(1)) == entry_q.count;
  assign q_pop_o   = load && !busy_q && q_stat_i.valid;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, ores_q};
  assign m_axis_tlast  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else if (load) begin
      if (busy_q) begin
        ovalid_q <= 1'b1;
        idx_q    <= idx_q + RES_IDX_W'(1);
        if (busy_last) busy_q <= 1'b0;
      end else if (q_stat_i.valid) begin
        // first beat goes straight from the queue head
        ovalid_q <= 1'b1;
        idx_q    <= RES_IDX_W'(1);
        busy_q   <= (q_head_i.count != RES_IDX_W'(1));
      end else begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (busy_q) begin
        ores_q  <= entry_q.res[idx_q];
        olast_q <= busy_last;
      end else if (q_stat_i.valid) begin
        entry_q <= q_head_i;
        ores_q  <= q_head_i.res[0];
        olast_q <= (q_head_i.count == RES_IDX_W'(1));
      end
    end
  end

endmodule
